// ===== rtl/tcg_pkg.sv =====
// Shared types, constants and the 5x7 font table for the text cursor glyph renderer.
// No dependencies; every other file imports this package.
package tcg_pkg;

    localparam int DEF_LINE_WIDTH_CHARS = 20;
    localparam int DEF_LINE_COUNT       = 20;

    localparam logic [1:0] MODE_PRINT       = 2'd0;
    localparam logic [1:0] MODE_SET_CURSOR  = 2'd1;
    localparam logic [1:0] MODE_CENTER_LINE = 2'd2;

    localparam logic REG_FOREGROUND = 1'b0;
    localparam logic REG_BACKGROUND = 1'b1;

    localparam logic [7:0] FIRST_CODE    = 8'd32;
    localparam logic [7:0] LAST_CODE     = 8'd126;
    localparam logic [7:0] FALLBACK_CODE = 8'd63;

    localparam logic [15:0] FOREGROUND_RESET = 16'hFFFF;
    localparam logic [15:0] BACKGROUND_RESET = 16'h0000;

    localparam logic [3:0] LAST_CELL_ROW = 4'd15;
    localparam logic [1:0] LAST_GROUP    = 2'd2;

    // One queued cell: five font columns (bit 0 is the top font row) and its origin
    typedef struct packed {
        logic [4:0][6:0] cols;
        logic [7:0]      origin_x;
        logic [8:0]      origin_y;
    } tcg_job_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic valid;
    } tcg_q_status_t;

    // Font columns in order, column 0 in the top byte
    function automatic logic [39:0] tcg_glyph(input logic [6:0] idx);
        logic [39:0] g;
        case (idx)
            7'd0:  g = 40'h0000000000;
            7'd1:  g = 40'h00005F0000;
            7'd2:  g = 40'h0007000700;
            7'd3:  g = 40'h147F147F14;
            7'd4:  g = 40'h242A7F2A12;
            7'd5:  g = 40'h2313086462;
            7'd6:  g = 40'h3649552250;
            7'd7:  g = 40'h0005030000;
            7'd8:  g = 40'h001C224100;
            7'd9:  g = 40'h0041221C00;
            7'd10: g = 40'h14083E0814;
            7'd11: g = 40'h08083E0808;
            7'd12: g = 40'h0050300000;
            7'd13: g = 40'h0808080808;
            7'd14: g = 40'h0060600000;
            7'd15: g = 40'h2010080402;
            7'd16: g = 40'h3E5149453E;
            7'd17: g = 40'h00427F4000;
            7'd18: g = 40'h4261514946;
            7'd19: g = 40'h2141454B31;
            7'd20: g = 40'h1814127F10;
            7'd21: g = 40'h2745454539;
            7'd22: g = 40'h3C4A494930;
            7'd23: g = 40'h0171090503;
            7'd24: g = 40'h3649494936;
            7'd25: g = 40'h064949291E;
            7'd26: g = 40'h0036360000;
            7'd27: g = 40'h0056360000;
            7'd28: g = 40'h0814224100;
            7'd29: g = 40'h1414141414;
            7'd30: g = 40'h0041221408;
            7'd31: g = 40'h0201510906;
            7'd32: g = 40'h324979413E;
            7'd33: g = 40'h7E1111117E;
            7'd34: g = 40'h7F49494936;
            7'd35: g = 40'h3E41414122;
            7'd36: g = 40'h7F4141221C;
            7'd37: g = 40'h7F49494941;
            7'd38: g = 40'h7F09090901;
            7'd39: g = 40'h3E4149497A;
            7'd40: g = 40'h7F0808087F;
            7'd41: g = 40'h00417F4100;
            7'd42: g = 40'h2040413F01;
            7'd43: g = 40'h7F08142241;
            7'd44: g = 40'h7F40404040;
            7'd45: g = 40'h7F020C027F;
            7'd46: g = 40'h7F0408107F;
            7'd47: g = 40'h3E4141413E;
            7'd48: g = 40'h7F09090906;
            7'd49: g = 40'h3E4151215E;
            7'd50: g = 40'h7F09192946;
            7'd51: g = 40'h4649494931;
            7'd52: g = 40'h01017F0101;
            7'd53: g = 40'h3F4040403F;
            7'd54: g = 40'h1F2040201F;
            7'd55: g = 40'h3F4038403F;
            7'd56: g = 40'h6314081463;
            7'd57: g = 40'h0708700807;
            7'd58: g = 40'h6151494543;
            7'd59: g = 40'h007F414100;
            7'd60: g = 40'h0204081020;
            7'd61: g = 40'h0041417F00;
            7'd62: g = 40'h0402010204;
            7'd63: g = 40'h4040404040;
            7'd64: g = 40'h0001020400;
            7'd65: g = 40'h2054545478;
            7'd66: g = 40'h7F48444438;
            7'd67: g = 40'h3844444420;
            7'd68: g = 40'h384444487F;
            7'd69: g = 40'h3854545418;
            7'd70: g = 40'h087E090102;
            7'd71: g = 40'h0C5252523E;
            7'd72: g = 40'h7F08040478;
            7'd73: g = 40'h00447D4000;
            7'd74: g = 40'h2040443D00;
            7'd75: g = 40'h7F10284400;
            7'd76: g = 40'h00417F4000;
            7'd77: g = 40'h7C04180478;
            7'd78: g = 40'h7C08040478;
            7'd79: g = 40'h3844444438;
            7'd80: g = 40'h7C14141408;
            7'd81: g = 40'h081414187C;
            7'd82: g = 40'h7C08040408;
            7'd83: g = 40'h4854545420;
            7'd84: g = 40'h043F444020;
            7'd85: g = 40'h3C4040207C;
            7'd86: g = 40'h1C2040201C;
            7'd87: g = 40'h3C4030403C;
            7'd88: g = 40'h4428102844;
            7'd89: g = 40'h0C5050503C;
            7'd90: g = 40'h4464544C44;
            7'd91: g = 40'h0008364100;
            7'd92: g = 40'h00007F0000;
            7'd93: g = 40'h0041360800;
            7'd94: g = 40'h1008081008;
            default: g = 40'h0000000000;
        endcase
        return g;
    endfunction

endpackage

// ===== rtl/tcg_front.sv =====
// Front end: takes requests, keeps the text cursor, and turns print requests into cell jobs.
// Depends on tcg_pkg.
module tcg_front
    import tcg_pkg::*;
#(
    parameter int LINE_WIDTH_CHARS = DEF_LINE_WIDTH_CHARS,
    parameter int LINE_COUNT       = DEF_LINE_COUNT
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [1:0]    mode,
    input  logic [7:0]    char_code,
    input  logic [7:0]    row_request,
    input  logic [7:0]    col_request,
    input  logic [7:0]    line_length,
    output logic          job_push,
    output tcg_job_t      job
);

    localparam logic [7:0] WIDTH8    = 8'(LINE_WIDTH_CHARS);
    localparam logic [7:0] COUNT8    = 8'(LINE_COUNT);
    localparam logic [4:0] WIDTH5    = 5'(LINE_WIDTH_CHARS);
    localparam logic [4:0] LAST_COL  = 5'(LINE_WIDTH_CHARS - 1);
    localparam logic [4:0] LAST_LINE = 5'(LINE_COUNT - 1);

    logic [4:0]  cursor_line_reg;
    logic [4:0]  cursor_line_next;
    logic [4:0]  cursor_position_reg;
    logic [4:0]  cursor_position_next;

    logic [4:0]  line_eff;
    logic [4:0]  pos_eff;
    logic [4:0]  row_clamped;
    logic [7:0]  len_clamped;
    logic [7:0]  code_eff;
    logic [6:0]  glyph_idx;
    logic [39:0] glyph_bits;
    logic [8:0]  ox_wide;

    always_comb
    begin
        // wrap to the next line once the previous line is full
        if (cursor_position_reg >= WIDTH5)
        begin
            pos_eff  = 5'd0;
            line_eff = (cursor_line_reg >= LAST_LINE) ? 5'd0 : cursor_line_reg + 5'd1;
        end
        else
        begin
            pos_eff  = cursor_position_reg;
            line_eff = cursor_line_reg;
        end

        row_clamped = (row_request >= COUNT8) ? LAST_LINE : row_request[4:0];
        len_clamped = (line_length > WIDTH8) ? WIDTH8 : line_length;

        code_eff  = (char_code < FIRST_CODE || char_code > LAST_CODE) ? FALLBACK_CODE
                                                                     : char_code;
        glyph_idx  = 7'(code_eff - FIRST_CODE);
        glyph_bits = tcg_glyph(glyph_idx);

        for (int c = 0; c < 5; c++)
        begin
            job.cols[c] = glyph_bits[38 - 8*c -: 7];
        end

        // column times twelve as eight plus four
        ox_wide      = {1'b0, pos_eff, 3'b000} + {2'b00, pos_eff, 2'b00};
        job.origin_x = ox_wide[7:0];
        job.origin_y = {line_eff, 4'b0000};

        cursor_line_next     = cursor_line_reg;
        cursor_position_next = cursor_position_reg;
        job_push             = 1'b0;
        if (accept)
        begin
            case (mode)
                MODE_PRINT:
                begin
                    job_push             = 1'b1;
                    cursor_line_next     = line_eff;
                    cursor_position_next = pos_eff + 5'd1;
                end
                MODE_SET_CURSOR:
                begin
                    cursor_line_next     = row_clamped;
                    cursor_position_next = (col_request >= WIDTH8) ? LAST_COL
                                                                   : col_request[4:0];
                end
                MODE_CENTER_LINE:
                begin
                    cursor_line_next     = row_clamped;
                    cursor_position_next = 5'((WIDTH8 - len_clamped) >> 1);
                end
                default:
                begin
                    cursor_line_next     = cursor_line_reg;
                    cursor_position_next = cursor_position_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_line_reg     <= 5'd0;
            cursor_position_reg <= 5'd0;
        end
        else
        begin
            cursor_line_reg     <= cursor_line_next;
            cursor_position_reg <= cursor_position_next;
        end
    end

`ifndef SYNTHESIS
    a_line_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_line_reg <= LAST_LINE)
        else $error("cursor line left the grid");

    a_pos_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_position_reg <= WIDTH5)
        else $error("cursor column beyond line width");
`endif

endmodule

// ===== rtl/tcg_queue.sv =====
// Two-entry job queue between the front end and the cell sequencer.
// Depends on tcg_pkg.
module tcg_queue
    import tcg_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tcg_job_t      push_job,
    input  logic          pop,
    output tcg_job_t      head_job,
    output tcg_q_status_t status
);

    tcg_job_t   entries_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign status.full  = (count_reg == 2'd2);
    assign status.valid = (count_reg != 2'd0);
    assign head_job     = entries_reg[rd_ptr_reg];

    always_comb
    begin
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_job;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'd2)
        else $error("job queue overflow");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != 2'd0)
        else $error("job queue popped while empty");
`endif

endmodule

// ===== rtl/tcg_back.sv =====
// Cell sequencer: walks the 16 pixel rows by 3 groups of a queued cell into an output register.
// Depends on tcg_pkg.
module tcg_back
    import tcg_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  tcg_job_t      head_job,
    input  logic          head_valid,
    output logic          head_pop,
    input  logic [15:0]   fg_color,
    input  logic [15:0]   bg_color,
    output logic          out_valid,
    input  logic          out_take,
    output logic [7:0]    origin_x,
    output logic [8:0]    origin_y,
    output logic [3:0]    cell_row,
    output logic [1:0]    group_index,
    output logic [15:0]   pixel_first,
    output logic [15:0]   pixel_second,
    output logic [15:0]   pixel_third,
    output logic [15:0]   pixel_fourth,
    output logic          last_of_cell
);

    logic [3:0]       row_reg;
    logic [3:0]       row_next;
    logic [1:0]       grp_reg;
    logic [1:0]       grp_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [7:0]       ox_reg;
    logic [8:0]       oy_reg;
    logic [3:0]       row_out_reg;
    logic [1:0]       grp_out_reg;
    logic [3:0][15:0] pix_reg;
    logic             last_reg;

    logic             emit;
    logic             cell_done;
    logic [2:0]       fy;
    logic [3:0][15:0] pix_calc;

    function automatic logic font_bit(input logic [4:0][6:0] cols,
                                      input logic [2:0] fx, input logic [2:0] fy_in);
        logic [6:0] col;
        case (fx)
            3'd0:    col = cols[0];
            3'd1:    col = cols[1];
            3'd2:    col = cols[2];
            3'd3:    col = cols[3];
            3'd4:    col = cols[4];
            default: col = 7'd0;
        endcase
        return (fy_in != 3'd7) && col[fy_in];
    endfunction

    assign emit      = head_valid && (!out_valid_reg || out_take);
    assign cell_done = (row_reg == LAST_CELL_ROW) && (grp_reg == LAST_GROUP);
    assign head_pop  = emit && cell_done;
    assign fy        = row_reg[3:1];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            pix_calc[i] = font_bit(head_job.cols, {grp_reg, 1'b0} + 3'(i >> 1), fy)
                          ? fg_color : bg_color;
        end

        row_next = row_reg;
        grp_next = grp_reg;
        if (emit)
        begin
            if (grp_reg == LAST_GROUP)
            begin
                grp_next = 2'd0;
                row_next = row_reg + 4'd1;
            end
            else
            begin
                grp_next = grp_reg + 2'd1;
            end
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_take)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg       <= 4'd0;
            grp_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            row_reg       <= row_next;
            grp_reg       <= grp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            ox_reg      <= head_job.origin_x;
            oy_reg      <= head_job.origin_y;
            row_out_reg <= row_reg;
            grp_out_reg <= grp_reg;
            pix_reg     <= pix_calc;
            last_reg    <= cell_done;
        end
    end

    assign out_valid    = out_valid_reg;
    assign origin_x     = ox_reg;
    assign origin_y     = oy_reg;
    assign cell_row     = row_out_reg;
    assign group_index  = grp_out_reg;
    assign pixel_first  = pix_reg[0];
    assign pixel_second = pix_reg[1];
    assign pixel_third  = pix_reg[2];
    assign pixel_fourth = pix_reg[3];
    assign last_of_cell = last_reg;

`ifndef SYNTHESIS
    a_grp_range: assert property (@(posedge clk) disable iff (!rst_n)
        grp_reg <= LAST_GROUP)
        else $error("group counter out of range");

    a_last_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && last_reg |-> row_out_reg == LAST_CELL_ROW
                                     && grp_out_reg == LAST_GROUP)
        else $error("end of cell flagged mid-cell");

    a_idle_at_start: assert property (@(posedge clk) disable iff (!rst_n)
        !head_valid |-> row_reg == 4'd0 && grp_reg == 2'd0)
        else $error("sequencer mid-cell without a job");
`endif

endmodule

// ===== rtl/text_cursor_glyph_renderer.sv =====
// Top level of the text cursor glyph renderer: colour registers, front end, job queue, sequencer.
// Depends on tcg_pkg, tcg_front, tcg_queue and tcg_back.
//
// A print request (mode 0) yields 48 results, one four-pixel group per cycle while pop is
// held, row-major over the 12x16 cell; the 48-step row/group counter of the cell sequencer
// sets that figure, and the next character's cell starts only after this one. Cursor requests
// (modes 1 and 2) and mode 3 complete in the cycle they are taken and give no result. A
// two-entry job queue sits between the front end and the sequencer, so requests keep being
// taken while a cell is drawn; the cell being drawn holds its entry until its last group,
// so full rises once one cell is being drawn and a second is queued behind it. Colour
// writes take effect at once and are meant for while no cell is in flight.
module text_cursor_glyph_renderer
    import tcg_pkg::*;
#(
    parameter int LINE_WIDTH_CHARS = DEF_LINE_WIDTH_CHARS,
    parameter int LINE_COUNT       = DEF_LINE_COUNT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  mode,
    input  logic [7:0]  char_code,
    input  logic [7:0]  row_request,
    input  logic [7:0]  col_request,
    input  logic [7:0]  line_length,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  origin_x,
    output logic [8:0]  origin_y,
    output logic [3:0]  cell_row,
    output logic [1:0]  group_index,
    output logic [15:0] pixel_first,
    output logic [15:0] pixel_second,
    output logic [15:0] pixel_third,
    output logic [15:0] pixel_fourth,
    output logic        last_of_cell,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    logic [15:0]   fg_reg;
    logic [15:0]   bg_reg;
    logic          accept;
    logic          job_push;
    tcg_job_t      job;
    tcg_job_t      head_job;
    tcg_q_status_t q_status;
    logic          head_pop;
    logic          out_valid;

    assign accept = push && !q_status.full;
    assign full   = q_status.full;
    assign empty  = !out_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_reg <= FOREGROUND_RESET;
            bg_reg <= BACKGROUND_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_FOREGROUND: fg_reg <= cfg_data;
                REG_BACKGROUND: bg_reg <= cfg_data;
                default:        fg_reg <= fg_reg;
            endcase
        end
    end

    tcg_front #(
        .LINE_WIDTH_CHARS (LINE_WIDTH_CHARS),
        .LINE_COUNT       (LINE_COUNT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .mode        (mode),
        .char_code   (char_code),
        .row_request (row_request),
        .col_request (col_request),
        .line_length (line_length),
        .job_push    (job_push),
        .job         (job)
    );

    tcg_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (job),
        .pop      (head_pop),
        .head_job (head_job),
        .status   (q_status)
    );

    tcg_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_job     (head_job),
        .head_valid   (q_status.valid),
        .head_pop     (head_pop),
        .fg_color     (fg_reg),
        .bg_color     (bg_reg),
        .out_valid    (out_valid),
        .out_take     (pop),
        .origin_x     (origin_x),
        .origin_y     (origin_y),
        .cell_row     (cell_row),
        .group_index  (group_index),
        .pixel_first  (pixel_first),
        .pixel_second (pixel_second),
        .pixel_third  (pixel_third),
        .pixel_fourth (pixel_fourth),
        .last_of_cell (last_of_cell)
    );

`ifndef SYNTHESIS
    a_push_only_taken: assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> accept && mode == MODE_PRINT)
        else $error("cell job queued without a print request");
`endif

endmodule
